// File: rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants for the positional array table: operation and
// status codes, the per-cell control word and the scanner result.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int SCAN_GROUP     = 8;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 5;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND = 3'd0,
    OP_DROP   = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_FIND   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic write;
    logic shift_up;
    logic shift_down;
    logic find_load;
  } cell_ctrl_t;

  typedef struct packed {
    logic                      done;
    logic signed [FOUND_W-1:0] found;
  } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/pat_cell.sv
// ----------------------------------------------------------------------------
// pat_cell
// One table slot: holds a word, takes its left or right neighbor on a shift,
// loads the request word at the target slot, and latches its find match.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_cell
  import pat_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  wire logic                          clk,
  input  wire cell_ctrl_t                    ctrl,
  input  wire logic [$clog2(CAPACITY)-1:0]   pos,
  input  wire logic [$clog2(CAPACITY+1)-1:0] count,
  input  wire logic [WORD_WIDTH-1:0]         word,
  input  wire logic [WORD_WIDTH-1:0]         left_q,
  input  wire logic [WORD_WIDTH-1:0]         right_q,
  output logic      [WORD_WIDTH-1:0]         data_q,
  output logic                               match_q
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] IDX_P = IW'(IDX);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [WORD_WIDTH-1:0] data_r, data_nxt;
  logic                  match_r, match_nxt;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (ctrl.write && (IDX_P == pos)) begin
      data_nxt = word;
    end else if (ctrl.shift_up && (IDX_P > pos)) begin
      data_nxt = left_q;
    end else if (ctrl.shift_down && (IDX_P >= pos)) begin
      data_nxt = right_q;
    end
    if (ctrl.find_load) begin
      match_nxt = (data_r == word) && (IDX_C < count);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data_q  = data_r;
  assign match_q = match_r;

endmodule

`default_nettype wire

// File: rtl/pat_scan.sv
// ----------------------------------------------------------------------------
// pat_scan
// Priority scanner over the latched match bits of the cells: examines one
// group of eight per cycle, lowest index first, and stops at the first hit.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_scan
  import pat_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                launch,
  input  wire logic [CAPACITY-1:0] match_vec,
  output logic                     busy,
  output scan_res_t                res
);

  localparam int NG = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int SW = $clog2(SCAN_GROUP);
  localparam int XW = GW + SW;
  localparam logic [GW-1:0] LAST_G = GW'(NG - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } scan_state_t;

  scan_state_t             state_r, state_nxt;
  logic [GW-1:0]           grp_r, grp_nxt;
  logic [NG*SCAN_GROUP-1:0] pad;
  logic [SCAN_GROUP-1:0]   grp_bits;
  logic [SW-1:0]           pe;
  logic                    hit;
  logic [XW-1:0]           idx;

  assign pad      = (NG*SCAN_GROUP)'(match_vec);
  assign grp_bits = pad[SCAN_GROUP*grp_r +: SCAN_GROUP];
  assign hit      = |grp_bits;

  always_comb begin
    pe = '0;
    for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        pe = SW'(k);
      end
    end
  end

  assign idx = {grp_r, pe};

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    res.done  = 1'b0;
    res.found = '1;
    unique case (state_r)
      S_IDLE: begin
        if (launch) begin
          state_nxt = S_SCAN;
          grp_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          res.done  = 1'b1;
          res.found = FOUND_W'(idx);
          state_nxt = S_IDLE;
        end else if (grp_r == LAST_G) begin
          res.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          grp_nxt = grp_r + GW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
    end
  end

  assign busy = (state_r == S_SCAN);

endmodule

`default_nettype wire

// File: rtl/positional_array_table.sv
// ----------------------------------------------------------------------------
// positional_array_table
// Ordered table of signed words with a live count, built as a row of cells
// that shift up or down together; supports append, drop last, insert, erase
// and find (lowest matching index).
//
//   channel  ports                                          handshake
//   input    in_func, in_position, in_value                start && !busy
//   result   out_status, out_found_index, out_entry_count  out_strobe
//
// Append, drop, insert and erase do not raise busy: a new item may follow in
// the next cycle, and its result shows on out_strobe in the cycle after accept.
// Find latches the match bits of all cells together, then the scanner checks
// eight of them per cycle while busy stays high; the result follows busy.
// Reset clears the count and the scanner; entry contents are not cleared.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_table
  import pat_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic        [FUNC_W-1:0]   in_func,
  input  wire logic        [POS_W-1:0]    in_position,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  output logic                            out_strobe,
  output logic             [STATUS_W-1:0] out_status,
  output logic signed      [FOUND_W-1:0]  out_found_index,
  output logic             [COUNT_W-1:0]  out_entry_count
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_C = CW'(CAPACITY);

  logic [CW-1:0]          count_r, count_nxt;
  logic                   strobe_r, strobe_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic signed [FOUND_W-1:0] found_r, found_nxt;
  logic [COUNT_W-1:0]     cnt_out_r, cnt_out_nxt;

  logic                   accept;
  logic                   full;
  logic [PW-1:0]          pos_w, cnt_w;
  logic [WORD_WIDTH-1:0]  word;
  cell_ctrl_t             ctrl;
  logic [IW-1:0]          cell_pos;
  logic                   scan_busy;
  scan_res_t              scan_res;

  logic [WORD_WIDTH-1:0]  cell_q [CAPACITY];
  logic [CAPACITY-1:0]    match_vec;

  assign accept = start && !busy;
  assign full   = (count_r == FULL_C);
  assign pos_w  = PW'(in_position);
  assign cnt_w  = PW'(count_r);
  assign word   = WORD_WIDTH'(in_value);
  assign busy   = scan_busy;

  always_comb begin
    ctrl        = '0;
    cell_pos    = pos_w[IW-1:0];
    count_nxt   = count_r;
    strobe_nxt  = 1'b0;
    status_nxt  = ST_DONE;
    found_nxt   = '1;
    cnt_out_nxt = COUNT_W'(count_r);
    if (accept) begin
      strobe_nxt = 1'b1;
      unique case (in_func)
        OP_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.write = 1'b1;
            cell_pos   = count_r[IW-1:0];
            count_nxt  = count_r + CW'(1);
          end
        end
        OP_DROP: begin
          if (count_r == '0) begin
            status_nxt = ST_IGNORED;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        OP_INSERT: begin
          if (pos_w > cnt_w) begin
            status_nxt = ST_IGNORED;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.write    = 1'b1;
            ctrl.shift_up = 1'b1;
            count_nxt     = count_r + CW'(1);
          end
        end
        OP_ERASE: begin
          if (pos_w >= cnt_w) begin
            status_nxt = ST_IGNORED;
          end else begin
            ctrl.shift_down = 1'b1;
            count_nxt       = count_r - CW'(1);
          end
        end
        OP_FIND: begin
          ctrl.find_load = 1'b1;
          strobe_nxt     = 1'b0;
        end
        default: begin
          status_nxt = ST_IGNORED;
        end
      endcase
      cnt_out_nxt = COUNT_W'(count_nxt);
    end else if (scan_res.done) begin
      strobe_nxt = 1'b1;
      found_nxt  = scan_res.found;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_q, right_q;
    if (i == 0) begin : g_first
      assign left_q = cell_q[i];
    end else begin : g_inner
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = cell_q[i];
    end else begin : g_body
      assign right_q = cell_q[i+1];
    end
    pat_cell #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .pos     (cell_pos),
      .count   (count_r),
      .word    (word),
      .left_q  (left_q),
      .right_q (right_q),
      .data_q  (cell_q[i]),
      .match_q (match_vec[i])
    );
  end

  pat_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .launch    (ctrl.find_load),
    .match_vec (match_vec),
    .busy      (scan_busy),
    .res       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    found_r   <= found_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found_index = found_r;
  assign out_entry_count = cnt_out_r;

  a_find_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == OP_FIND) |=> busy)
    else $error("find item did not start the scan");

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result shown while the scan is running");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_func == OP_APPEND) && !full |=>
      out_strobe && (count_r == $past(count_r) + CW'(1)))
    else $error("append did not advance the count");

endmodule

`default_nettype wire

// File: test/positional_array_table_test.sv
// ----------------------------------------------------------------------------
// positional_array_table_test
// Self-checking bench for the positional array table. A directed run hits
// the empty and out-of-range corners, value extremes, duplicates and
// the spare operation codes. Grow, shrink and mixed phases of random items
// follow, with and without idle gaps between items. A scoreboard keeps its
// own copy of the table, predicts every result, and checks each strobed
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_array_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pat_pkg::*;

  localparam int TABLE_DEPTH = CAPACITY_DEF;
  localparam logic [FUNC_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_HI  = 3'd7;
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  typedef struct {
    status_t                   status;
    logic signed [FOUND_W-1:0] found_index;
    logic        [COUNT_W-1:0] entry_count;
  } table_result_t;

  class table_scoreboard;
    logic signed [VALUE_W-1:0] cells [TABLE_DEPTH];
    int unsigned               live_count;
    table_result_t             pending_q [$];
    int                        errors;
    int                        results;
    int                        op_seen [8];
    int                        full_refusals;
    int                        ignored;
    int                        find_hits;

    function new();
      live_count = 0;
      errors = 0;
      results = 0;
      full_refusals = 0;
      ignored = 0;
      find_hits = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function void note_item(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                            logic signed [VALUE_W-1:0] v);
      table_result_t r;
      int            i;
      bit            hit;
      r.status = ST_DONE;
      r.found_index = '1;
      hit = 0;
      case (f)
        OP_APPEND: begin
          if (live_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            cells[live_count] = v;
            live_count++;
          end
        end
        OP_DROP: begin
          if (live_count == 0) r.status = ST_IGNORED;
          else live_count--;
        end
        OP_INSERT: begin
          if (p > live_count) begin
            r.status = ST_IGNORED;
          end else if (live_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = live_count; i > p; i--) cells[i] = cells[i-1];
            cells[p] = v;
            live_count++;
          end
        end
        OP_ERASE: begin
          if (p >= live_count) begin
            r.status = ST_IGNORED;
          end else begin
            for (i = p + 1; i < live_count; i++) cells[i-1] = cells[i];
            live_count--;
          end
        end
        OP_FIND: begin
          for (i = 0; i < live_count; i++) begin
            if (!hit && cells[i] == v) begin
              hit = 1;
              r.found_index = FOUND_W'(i);
            end
          end
          if (hit) find_hits++;
        end
        default: r.status = ST_IGNORED;
      endcase
      r.entry_count = COUNT_W'(live_count);
      op_seen[f]++;
      if (r.status == ST_FULL) full_refusals++;
      if (r.status == ST_IGNORED) ignored++;
      pending_q = {pending_q, r};
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic signed [FOUND_W-1:0] fi,
                               logic [COUNT_W-1:0] cnt);
      table_result_t e;
      results++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing pending: status %0d index %0d count %0d",
                   $realtime, st, fi, cnt);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status || fi !== e.found_index || cnt !== e.entry_count) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected status %0d index %0d count %0d, got %0d %0d %0d",
                   $realtime, e.status, e.found_index, e.entry_count, st, fi, cnt);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic        [FUNC_W-1:0]   in_func = '0;
  logic        [POS_W-1:0]    in_position = '0;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       busy;
  logic                       out_strobe;
  logic        [STATUS_W-1:0] out_status;
  logic signed [FOUND_W-1:0]  out_found_index;
  logic        [COUNT_W-1:0]  out_entry_count;

  table_scoreboard sb = new();
  bit              idle_on;

  positional_array_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_status, out_found_index, out_entry_count);
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic [VALUE_W-1:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_position <= p;
    in_value <= v;
    do @(posedge clk); while (busy);
    sb.note_item(f, p, v);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(bit prefer_stored);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (prefer_stored && sb.live_count > 0 && $urandom_range(0, 1) == 1)
      return sb.cells[$urandom_range(0, sb.live_count - 1)];
    case (sel)
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return VALUE_W'($signed($urandom_range(0, 7)) - 4);
      7:          return 32'h8000_0000;
      8:          return 32'h7FFF_FFFF;
      default:    return (sb.live_count > 0) ? sb.cells[$urandom_range(0, sb.live_count - 1)]
                                             : $urandom;
    endcase
  endfunction

  task automatic random_item(input int mode);
    int unsigned           roll;
    logic [FUNC_W-1:0]     f;
    logic [POS_W-1:0]      p;
    int unsigned           top;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:
        f = (roll < 40) ? OP_APPEND : (roll < 70) ? OP_INSERT : (roll < 90) ? OP_FIND :
            (roll < 95) ? OP_ERASE : (roll < 98) ? OP_DROP : OP_SPARE_LO;
      MODE_SHRINK:
        f = (roll < 30) ? OP_DROP : (roll < 65) ? OP_ERASE : (roll < 85) ? OP_FIND :
            (roll < 92) ? OP_APPEND : (roll < 98) ? OP_INSERT : OP_SPARE_LO;
      default:
        f = (roll < 18) ? OP_APPEND : (roll < 36) ? OP_DROP : (roll < 55) ? OP_INSERT :
            (roll < 72) ? OP_ERASE : (roll < 97) ? OP_FIND : OP_SPARE_LO;
    endcase
    if (f == OP_SPARE_LO) f = FUNC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if ($urandom_range(0, 9) == 0) begin
      p = POS_W'($urandom_range(0, 31));
    end else begin
      top = (f == OP_ERASE && sb.live_count > 0) ? sb.live_count - 1 : sb.live_count;
      p = POS_W'($urandom_range(0, top));
    end
    send_item(f, p, pick_value(f == OP_FIND));
  endtask

  initial begin
    int drain;
    int mode;
    idle_on = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table corners
    send_item(OP_FIND,      5'd0,  32'h0000_0000);
    send_item(OP_DROP,      5'd0,  32'h0000_0000);
    send_item(OP_ERASE,     5'd0,  32'h0000_0000);
    send_item(OP_INSERT,    5'd1,  32'h0000_0001);
    send_item(OP_SPARE_LO,  5'd0,  32'h0000_0000);
    // build up with extremes and duplicates
    send_item(OP_INSERT,    5'd0,  32'h8000_0000);
    send_item(OP_APPEND,    5'd0,  32'h7FFF_FFFF);
    send_item(OP_APPEND,    5'd31, 32'hFFFF_FFFF);
    send_item(OP_APPEND,    5'd0,  32'h0000_0000);
    send_item(OP_INSERT,    5'd2,  32'h1234_5678);
    send_item(OP_INSERT,    5'd5,  32'hFFFF_FFFF);
    send_item(OP_FIND,      5'd0,  32'hFFFF_FFFF);
    send_item(OP_FIND,      5'd0,  32'h8000_0000);
    send_item(OP_FIND,      5'd0,  32'h7FFF_FFFF);
    send_item(OP_FIND,      5'd0,  32'h5555_5555);
    // erase at head and tail, then out of range
    send_item(OP_ERASE,     5'd0,  32'h0000_0000);
    send_item(OP_ERASE,     5'd4,  32'h0000_0000);
    send_item(OP_ERASE,     5'd31, 32'hAAAA_AAAA);
    send_item(OP_INSERT,    5'd16, 32'h0000_0002);
    send_item(OP_SPARE_MID, 5'd3,  32'hFFFF_FFFF);
    send_item(OP_SPARE_HI,  5'd31, 32'h8000_0000);
    send_item(OP_DROP,      5'd0,  32'h0000_0000);
    send_item(OP_FIND,      5'd0,  32'h0000_0000);

    for (int ph = 0; ph < 9; ph++) begin
      mode = (ph % 3 == 0) ? MODE_GROW : (ph % 3 == 1) ? MODE_MIXED : MODE_SHRINK;
      idle_on = (ph == 1 || ph == 5) ? 0 : ($urandom_range(0, 3) != 0);
      repeat (59) random_item(mode);
    end

    start <= 1'b0;
    drain = 0;
    while (sb.pending_q.size() != 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $display("%0d results never arrived", sb.pending_q.size());
      sb.errors += sb.pending_q.size();
    end

    $display("covered %0d append, %0d drop, %0d insert, %0d erase, %0d find, %0d spare-code items",
             sb.op_seen[OP_APPEND], sb.op_seen[OP_DROP], sb.op_seen[OP_INSERT],
             sb.op_seen[OP_ERASE], sb.op_seen[OP_FIND],
             sb.op_seen[OP_SPARE_LO] + sb.op_seen[OP_SPARE_MID] + sb.op_seen[OP_SPARE_HI]);
    $display("%0d results checked: %0d full refusals, %0d ignored, %0d find hits, %0d errors",
             sb.results, sb.full_refusals, sb.ignored, sb.find_hits, sb.errors);
    if (sb.errors == 0) begin
      $display("positional_array_table_test: clean");
    end else begin
      $display("positional_array_table_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting on the table");
    $display("positional_array_table_test: errors");
    $finish;
  end

endmodule
